// ----- rtl/ust_pkg.sv -----
// ----------------------------------------------------------------------------
// ust_pkg
// shared word types, register codes and pipeline depths of the uv sphere core
// ----------------------------------------------------------------------------
package ust_pkg;

  // one grid cell as it enters the core
  typedef struct packed {
    logic [7:0] ring_index;
    logic [7:0] segment_index;
  } in_word_t;

  // one vertex with its two quad triangles
  typedef struct packed {
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic signed [15:0] z_coord;
    logic               upper_valid;
    logic [15:0]        upper_a;
    logic [15:0]        upper_b;
    logic [15:0]        upper_c;
    logic               lower_valid;
    logic [15:0]        lower_a;
    logic [15:0]        lower_b;
    logic [15:0]        lower_c;
    logic               invalid;
  } out_word_t;

  // register file
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  typedef logic [0:0] cfg_reg_t;
  localparam cfg_reg_t REG_SEGMENT_COUNT = 1'b0;
  localparam cfg_reg_t REG_RING_COUNT    = 1'b1;
  localparam logic [7:0] SEGMENT_COUNT_RST = 8'd16;
  localparam logic [7:0] RING_COUNT_RST    = 8'd16;

  // phase divider
  localparam int unsigned DIV_NUM_W = 25;
  localparam int unsigned DIV_DEN_W = 9;
  localparam int unsigned DIV_QUO_W = 17;
  localparam int unsigned DIV_LAT   = DIV_QUO_W + 1;

  // sine / cosine unit
  localparam int unsigned PHASE_W  = 16;
  localparam int unsigned MAG_W    = 31;
  localparam int unsigned TRIG_LAT = 22;

endpackage

// ----- rtl/uv_sphere_tessellator_core.sv -----
// ----------------------------------------------------------------------------
// uv_sphere_tessellator_core
// vertex and quad triangles of one uv sphere grid cell per word
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------
//  in      | in        | in_valid_i/in_ready_o | ust_pkg::in_word_t (i, j)
//  out     | out       | out_valid_o/out_ready_i| ust_pkg::out_word_t
//  cfg     | in        | apb psel/penable       | segment_count, ring_count
//
//  one word per cycle while the output does not stall; a word passes through
//  the 18-stage phase divider and the 22-stage sine unit
//  reset clears valid bits and loads both counts with 16
//  a stall at the output fills a one-word skid stage, after which in_ready_o
//  drops and the whole pipeline holds
// ----------------------------------------------------------------------------
module uv_sphere_tessellator_core #(
  parameter int unsigned COORD_FRAC = 15
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ust_pkg::in_word_t                 in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output ust_pkg::out_word_t                out_word_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ust_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [ust_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [ust_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int unsigned LINE  = ust_pkg::DIV_LAT + ust_pkg::TRIG_LAT;
  localparam int unsigned SH_X  = 60 - COORD_FRAC;
  localparam int unsigned SH_Y  = 30 - COORD_FRAC;
  localparam int unsigned MW    = ust_pkg::MAG_W;

  // ---------------------------------------------------------------- registers
  logic [7:0] seg_q, ring_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q  <= ust_pkg::SEGMENT_COUNT_RST;
      ring_q <= ust_pkg::RING_COUNT_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        ust_pkg::REG_SEGMENT_COUNT: seg_q  <= pwdata[7:0];
        ust_pkg::REG_RING_COUNT:    ring_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      ust_pkg::REG_SEGMENT_COUNT: prdata = ust_pkg::CFG_DATA_W'(seg_q);
      ust_pkg::REG_RING_COUNT:    prdata = ust_pkg::CFG_DATA_W'(ring_q);
      default:                    prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // ------------------------------------------------------- pipeline enable
  logic en;
  logic skid_vld_q;

  assign en         = ~skid_vld_q;
  assign in_ready_o = en;

  // ------------------------------------------------------------ phase divide
  // polar phase = (i*65536 + rings) / (2*rings)
  // azimuth phase = (j*131072 + segs) / (2*segs), full turn wraps to zero
  logic [ust_pkg::DIV_NUM_W-1:0] pol_num, azi_num;
  logic [ust_pkg::DIV_DEN_W-1:0] pol_den, azi_den;
  logic [ust_pkg::DIV_QUO_W-1:0] pol_quo, azi_quo;

  assign pol_num = ust_pkg::DIV_NUM_W'({in_word_i.ring_index, 16'h0000})
                 + ust_pkg::DIV_NUM_W'(ring_q);
  assign azi_num = ust_pkg::DIV_NUM_W'({in_word_i.segment_index, 17'h00000})
                 + ust_pkg::DIV_NUM_W'(seg_q);
  assign pol_den = {ring_q, 1'b0};
  assign azi_den = {seg_q, 1'b0};

  ust_div u_div_pol (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (pol_num),
    .den_i (pol_den),
    .quo_o (pol_quo)
  );

  ust_div u_div_azi (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (azi_num),
    .den_i (azi_den),
    .quo_o (azi_quo)
  );

  // ------------------------------------------------------------ sine/cosine
  logic [MW-1:0] pol_sin, pol_cos, azi_sin, azi_cos;
  logic          pol_sin_neg, pol_cos_neg, azi_sin_neg, azi_cos_neg;

  ust_trig u_trig_pol (
    .clk_i     (clk_i),
    .en_i      (en),
    .phase_i   (pol_quo[ust_pkg::PHASE_W-1:0]),
    .sin_mag_o (pol_sin),
    .sin_neg_o (pol_sin_neg),
    .cos_mag_o (pol_cos),
    .cos_neg_o (pol_cos_neg)
  );

  ust_trig u_trig_azi (
    .clk_i     (clk_i),
    .en_i      (en),
    .phase_i   (azi_quo[ust_pkg::PHASE_W-1:0]),
    .sin_mag_o (azi_sin),
    .sin_neg_o (azi_sin_neg),
    .cos_mag_o (azi_cos),
    .cos_neg_o (azi_cos_neg)
  );

  // cell indices and valid bits ride alongside the arithmetic
  logic [LINE-1:0]   vld_q;
  ust_pkg::in_word_t meta_q [LINE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LINE-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[0] <= in_word_i;
      for (int k = 1; k < LINE; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  // --------------------------------------------------- position products
  logic              p_vld_q;
  ust_pkg::in_word_t p_meta_q;
  logic [2*MW-1:0]   p_xmag_q, p_zmag_q;
  logic [MW-1:0]     p_ymag_q;
  logic              p_xneg_q, p_yneg_q, p_zneg_q;
  logic [16:0]       p_first_q;
  logic [16:0]       first_w;

  // first vertex of the quad: i*(segs+1) + j
  assign first_w = 17'(meta_q[LINE-1].ring_index) * 17'({1'b0, seg_q} + 9'd1)
                 + 17'(meta_q[LINE-1].segment_index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en) begin
      p_vld_q <= vld_q[LINE-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_meta_q  <= meta_q[LINE-1];
      p_xmag_q  <= (2*MW)'(pol_sin) * (2*MW)'(azi_cos);
      p_zmag_q  <= (2*MW)'(pol_sin) * (2*MW)'(azi_sin);
      p_ymag_q  <= pol_cos;
      p_xneg_q  <= pol_sin_neg ^ azi_cos_neg;
      p_zneg_q  <= pol_sin_neg ^ azi_sin_neg;
      p_yneg_q  <= pol_cos_neg;
      p_first_q <= first_w;
    end
  end

  // ------------------------------------------------- rounding and indices
  function automatic logic [15:0] sat_coord(input logic [62:0] r, input logic neg);
    logic [15:0] m;
    if (neg) begin
      m = (r > 63'd32768) ? 16'h8000 : r[15:0];
      sat_coord = ~m + 16'd1;
    end else begin
      m = (r > 63'd32767) ? 16'h7fff : r[15:0];
      sat_coord = m;
    end
  endfunction

  logic [62:0]        rx_w, ry_w, rz_w;
  logic               inval_w, inner_w;
  logic [16:0]        last_w;
  ust_pkg::out_word_t word_w;
  logic [7:0]         ci, cj;

  assign ci = p_meta_q.ring_index;
  assign cj = p_meta_q.segment_index;

  // half-up rounding: (2*mag + 2^sh) >> (sh+1), also right for a zero shift
  assign rx_w = (63'({p_xmag_q, 1'b0}) + (63'd1 << SH_X)) >> (SH_X + 1);
  assign rz_w = (63'({p_zmag_q, 1'b0}) + (63'd1 << SH_X)) >> (SH_X + 1);
  assign ry_w = (63'({p_ymag_q, 1'b0}) + (63'd1 << SH_Y)) >> (SH_Y + 1);

  assign inval_w = (seg_q == 8'd0) || (ring_q == 8'd0) || (ci > ring_q) || (cj > seg_q);
  assign inner_w = (ci < ring_q) && (cj < seg_q);
  assign last_w  = p_first_q + 17'(seg_q) + 17'd1;

  always_comb begin
    word_w = '0;
    word_w.invalid = inval_w;
    if (!inval_w) begin
      word_w.x_coord = sat_coord(rx_w, p_xneg_q);
      word_w.y_coord = sat_coord(ry_w, p_yneg_q);
      word_w.z_coord = sat_coord(rz_w, p_zneg_q);
      // top cap has no upper triangle
      if (inner_w && ci != 8'd0) begin
        word_w.upper_valid = 1'b1;
        word_w.upper_a     = 16'(p_first_q + 17'd1);
        word_w.upper_b     = last_w[15:0];
        word_w.upper_c     = p_first_q[15:0];
      end
      // bottom cap has no lower triangle
      if (inner_w && (9'(ci) + 9'd1) != 9'(ring_q)) begin
        word_w.lower_valid = 1'b1;
        word_w.lower_a     = 16'(last_w + 17'd1);
        word_w.lower_b     = last_w[15:0];
        word_w.lower_c     = 16'(p_first_q + 17'd1);
      end
    end
  end

  logic               r_vld_q;
  ust_pkg::out_word_t r_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
    end else if (en) begin
      r_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_word_q <= word_w;
    end
  end

  // ------------------------------------------------- output and skid stage
  logic               out_vld_q;
  ust_pkg::out_word_t out_word_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || out_ready_i) begin
      out_vld_q  <= skid_vld_q | r_vld_q;
      skid_vld_q <= 1'b0;
    end else if (r_vld_q && en) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_ready_i) begin
      out_word_q <= skid_vld_q ? skid_q : r_word_q;
    end else if (r_vld_q && en) begin
      skid_q <= r_word_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- rtl/ust_div.sv -----
// ----------------------------------------------------------------------------
// ust_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module ust_div (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [ust_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [ust_pkg::DIV_DEN_W-1:0]  den_i,
  output logic [ust_pkg::DIV_QUO_W-1:0]  quo_o
);

  localparam int unsigned NW = ust_pkg::DIV_NUM_W;
  localparam int unsigned DW = ust_pkg::DIV_DEN_W;
  localparam int unsigned QW = ust_pkg::DIV_QUO_W;

  logic [NW-1:0] rem_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int unsigned B = QW - 1 - k;
    logic [NW:0] sub_w;
    logic        ge_w;
    logic [NW:0] diff_w;

    assign sub_w  = (NW+1)'(den_q[k]) << B;
    assign ge_w   = {1'b0, rem_q[k]} >= sub_w;
    assign diff_w = {1'b0, rem_q[k]} - sub_w;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge_w ? diff_w[NW-1:0] : rem_q[k];
        den_q[k+1] <= den_q[k];
        quo_q[k+1] <= quo_q[k] | (QW'(ge_w) << B);
      end
    end
  end

  assign quo_o = quo_q[QW];

endmodule

// ----- rtl/ust_trig.sv -----
// ----------------------------------------------------------------------------
// ust_trig
// pipelined sine and cosine of a 16-bit turn phase, q30 magnitude and sign
// ----------------------------------------------------------------------------
module ust_trig (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [ust_pkg::PHASE_W-1:0]  phase_i,
  output logic [ust_pkg::MAG_W-1:0]    sin_mag_o,
  output logic                         sin_neg_o,
  output logic [ust_pkg::MAG_W-1:0]    cos_mag_o,
  output logic                         cos_neg_o
);

  localparam int unsigned NSTEP = 6;
  localparam int unsigned NSIN  = 5;
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam int unsigned SIN_N [NSTEP] = '{110, 72, 42, 20, 6, 1};
  localparam int unsigned COS_N [NSTEP] = '{132, 90, 56, 30, 12, 2};

  // angle in q30 radians and its square
  logic [46:0] thp_w;
  logic [30:0] th1_q;
  logic [1:0]  quad1_q;
  logic [61:0] tsq_w;
  logic [31:0] t2_q;
  logic [30:0] th2_q;
  logic [1:0]  quad2_q;

  assign thp_w = 47'(phase_i[13:0]) * 47'(PI_Q30) + 47'd16384;
  assign tsq_w = 62'(th1_q) * 62'(th1_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      th1_q   <= thp_w[45:15];
      quad1_q <= phase_i[15:14];
      t2_q    <= tsq_w[61:30];
      th2_q   <= th1_q;
      quad2_q <= quad1_q;
    end
  end

  logic [31:0] st_t    [NSTEP];
  logic [30:0] st_th   [NSTEP+1];
  logic [1:0]  st_quad [NSTEP+1];
  logic [30:0] st_bs   [NSTEP+1];
  logic [30:0] st_bc   [NSTEP+1];

  assign st_t[0]    = t2_q;
  assign st_th[0]   = th2_q;
  assign st_quad[0] = quad2_q;
  assign st_bs[0]   = Q30_ONE;
  assign st_bc[0]   = Q30_ONE;

  // horner brackets: product, reciprocal multiply, remainder fix and clamp
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    localparam logic [32:0] MC = 33'h1_0000_0000 / COS_N[k];

    logic [30:0] a_th_q, b_th_q, c_th_q;
    logic [1:0]  a_quad_q, b_quad_q, c_quad_q;
    logic [31:0] a_vc_q, b_vc_q, b_qc_q;
    logic [30:0] c_bc_q;
    logic [62:0] pc_w;
    logic [64:0] mc_w;
    logic [39:0] rc_w;
    logic [32:0] qc_w;
    logic [30:0] bc_w;

    assign pc_w = 63'(st_t[k]) * 63'(st_bc[k]);
    assign mc_w = 65'(a_vc_q) * 65'(MC);
    assign rc_w = 40'(b_vc_q) - 40'(b_qc_q) * 40'(COS_N[k]);
    assign qc_w = 33'(b_qc_q) + ((rc_w >= 40'(COS_N[k])) ? 33'd1 : 33'd0);
    assign bc_w = (qc_w < 33'(Q30_ONE)) ? 31'(33'(Q30_ONE) - qc_w) : '0;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_th_q   <= st_th[k];
        a_quad_q <= st_quad[k];
        a_vc_q   <= pc_w[61:30];
        b_th_q   <= a_th_q;
        b_quad_q <= a_quad_q;
        b_vc_q   <= a_vc_q;
        b_qc_q   <= mc_w[63:32];
        c_th_q   <= b_th_q;
        c_quad_q <= b_quad_q;
        c_bc_q   <= bc_w;
      end
    end

    assign st_th[k+1]   = c_th_q;
    assign st_quad[k+1] = c_quad_q;
    assign st_bc[k+1]   = c_bc_q;

    if (k + 1 < NSTEP) begin : g_tcarry
      logic [31:0] a_t_q, b_t_q, c_t_q;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          a_t_q <= st_t[k];
          b_t_q <= a_t_q;
          c_t_q <= b_t_q;
        end
      end
      assign st_t[k+1] = c_t_q;
    end

    if (k < NSIN) begin : g_sin
      localparam logic [32:0] MS = 33'h1_0000_0000 / SIN_N[k];
      logic [31:0] a_vs_q, b_vs_q, b_qs_q;
      logic [30:0] c_bs_q;
      logic [62:0] ps_w;
      logic [64:0] ms_w;
      logic [39:0] rs_w;
      logic [32:0] qs_w;
      logic [30:0] bs_w;

      assign ps_w = 63'(st_t[k]) * 63'(st_bs[k]);
      assign ms_w = 65'(a_vs_q) * 65'(MS);
      assign rs_w = 40'(b_vs_q) - 40'(b_qs_q) * 40'(SIN_N[k]);
      assign qs_w = 33'(b_qs_q) + ((rs_w >= 40'(SIN_N[k])) ? 33'd1 : 33'd0);
      assign bs_w = (qs_w < 33'(Q30_ONE)) ? 31'(33'(Q30_ONE) - qs_w) : '0;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          a_vs_q <= ps_w[61:30];
          b_vs_q <= a_vs_q;
          b_qs_q <= ms_w[63:32];
          c_bs_q <= bs_w;
        end
      end
      assign st_bs[k+1] = c_bs_q;
    end else begin : g_sin_hold
      // sine series is one bracket shorter, bracket just rides along
      logic [30:0] a_bs_q, b_bs_q, c_bs_q;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          a_bs_q <= st_bs[k];
          b_bs_q <= a_bs_q;
          c_bs_q <= b_bs_q;
        end
      end
      assign st_bs[k+1] = c_bs_q;
    end
  end

  // sine = theta * bracket, then quadrant fold
  logic [61:0] sv_w;
  logic [30:0] s_sv_q, s_cv_q;
  logic [1:0]  s_quad_q;

  assign sv_w = 62'(st_th[NSTEP]) * 62'(st_bs[NSTEP]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_sv_q    <= sv_w[60:30];
      s_cv_q    <= st_bc[NSTEP];
      s_quad_q  <= st_quad[NSTEP];
      sin_mag_o <= s_quad_q[0] ? s_cv_q : s_sv_q;
      sin_neg_o <= s_quad_q[1];
      cos_mag_o <= s_quad_q[0] ? s_sv_q : s_cv_q;
      cos_neg_o <= s_quad_q[1] ^ s_quad_q[0];
    end
  end

endmodule

// ----- rtl/ust_chk.sv -----
// ----------------------------------------------------------------------------
// ust_chk
// port-level checks of the uv sphere core, bound to the top level
// ----------------------------------------------------------------------------
module ust_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ust_pkg::out_word_t out_word_o
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // rejected cells carry nothing else
  a_invalid_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.invalid |->
      out_word_o.x_coord == 16'sd0 && out_word_o.y_coord == 16'sd0 &&
      out_word_o.z_coord == 16'sd0 && !out_word_o.upper_valid && !out_word_o.lower_valid)
    else $error("invalid word with live fields");

  // upper triangle: first+1, last, first
  a_upper_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.upper_valid |->
      out_word_o.upper_a == out_word_o.upper_c + 16'd1)
    else $error("upper triangle indices inconsistent");

  // both triangles share the diagonal of the quad
  a_shared_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.upper_valid && out_word_o.lower_valid |->
      out_word_o.upper_a == out_word_o.lower_c && out_word_o.upper_b == out_word_o.lower_b &&
      out_word_o.lower_a == out_word_o.lower_b + 16'd1)
    else $error("quad triangles do not share their diagonal");

endmodule

bind uv_sphere_tessellator_core ust_chk u_ust_chk (.*);
